// ----- hdl/dspq_pkg.sv -----
// Package for the distance-sorted point queue.
// Request codes, sizes and the sequencer state type; no dependencies.
package dspq_pkg;
  localparam int CAPACITY    = 64;
  localparam int COORD_WIDTH = 16;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int KEY_W       = 2 * COORD_WIDTH + 1;
  localparam int ENT_W       = KEY_W + 2 * COORD_WIDTH;

  typedef enum logic [2:0] {
    REQ_INSERT  = 3'd0,
    REQ_RM_HEAD = 3'd1,
    REQ_RM_TAIL = 3'd2,
    REQ_RM_AT   = 3'd3,
    REQ_DEDUP   = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_RM,
    ST_DD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]       key;
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
  } entry_t;
endpackage

// ----- hdl/distance_sorted_point_queue_core.sv -----
// Distance-sorted point queue: entries held in one RAM, walked one entry a cycle.
// Insert walks from the tail down to its rank, remove from its rank up to the tail,
// dedup over every entry; failed, unknown, first-insert or short dedup skip the walk.
// done_o lasts one cycle with busy held; next start accepted in the cycle after at earliest.
// Reset clears the fill count and sequencer; RAM contents are undefined until written.
// Depends on dspq_pkg and dspq_ram; the receiver cannot stall.
module distance_sorted_point_queue_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [2:0]                         req_type_i,
  input  logic signed [dspq_pkg::COORD_WIDTH-1:0] x_coord_i,
  input  logic signed [dspq_pkg::COORD_WIDTH-1:0] y_coord_i,
  input  logic [5:0]                         position_i,
  output logic                               done_o,
  output logic                               ok_o,
  output logic signed [dspq_pkg::COORD_WIDTH-1:0] out_x_o,
  output logic signed [dspq_pkg::COORD_WIDTH-1:0] out_y_o,
  output logic [5:0]                         removed_count_o,
  output logic [6:0]                         entry_count_o
);
  localparam int IW = dspq_pkg::IDX_W;
  localparam int CW = dspq_pkg::CNT_W;
  localparam int DW = dspq_pkg::COORD_WIDTH;
  localparam int KW = dspq_pkg::KEY_W;

  dspq_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] ptr_q, ptr_d;     // next RAM address to read
  logic [CW-1:0] wp_q, wp_d;       // dedup write pointer; all ones flags a head insert
  logic          rv_q, rv_d;       // RAM data valid this cycle
  logic [CW-1:0] rptr_q, rptr_d;   // address of data being returned
  dspq_pkg::entry_t new_q, new_d, last_q, last_d;
  logic [5:0]    dups_q, dups_d;
  logic          ok_q, ok_d, done_q, done_d;
  logic [DW-1:0] ox_q, ox_d, oy_q, oy_d;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  dspq_pkg::entry_t wdata, rdata;

  dspq_ram #(.WIDTH(dspq_pkg::ENT_W), .DEPTH(dspq_pkg::CAPACITY)) u_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic signed [DW:0] ax, ay;
  logic [2*DW-1:0] sqx, sqy;
  logic [KW-1:0] key_in;
  logic stays;

  always_comb begin
    ax = x_coord_i[DW-1] ? -{x_coord_i[DW-1], x_coord_i} : {1'b0, x_coord_i};
    ay = y_coord_i[DW-1] ? -{y_coord_i[DW-1], y_coord_i} : {1'b0, y_coord_i};
    sqx = ax[DW-1:0] * ax[DW-1:0];
    sqy = ay[DW-1:0] * ay[DW-1:0];
    key_in = KW'(sqx) + KW'(sqy);
    if (rdata.key != new_q.key)   stays = rdata.key < new_q.key;
    else if (rdata.x != new_q.x)  stays = $signed(rdata.x) < $signed(new_q.x);
    else                          stays = $signed(rdata.y) <= $signed(new_q.y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dspq_pkg::ST_IDLE;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d; wp_q <= wp_d; rptr_q <= rptr_d;
    new_q <= new_d; last_q <= last_d; dups_q <= dups_d;
    ok_q <= ok_d; ox_q <= ox_d; oy_q <= oy_d;
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; ptr_d = ptr_q; wp_d = wp_q;
    rv_d = 1'b0; rptr_d = ptr_q; new_d = new_q; last_d = last_q;
    dups_d = dups_q; ok_d = ok_q; ox_d = ox_q; oy_d = oy_q;
    done_d = 1'b0;
    we = 1'b0; waddr = '0; wdata = new_q; raddr = ptr_q[IW-1:0];
    unique case (state_q)
      dspq_pkg::ST_IDLE: begin
        // hold off while the previous result is still on the ports
        if (start && !done_q) begin
          ok_d = 1'b0; ox_d = '0; oy_d = '0; dups_d = '0;
          new_d = '{key: key_in, x: x_coord_i, y: y_coord_i};
          state_d = dspq_pkg::ST_DONE;
          unique case (req_type_i) inside
            dspq_pkg::REQ_INSERT: if (cnt_q < CW'(dspq_pkg::CAPACITY)) begin
              if (cnt_q == '0) begin
                we = 1'b1; waddr = '0;
                wdata = '{key: key_in, x: x_coord_i, y: y_coord_i};
                cnt_d = CW'(1); ok_d = 1'b1;
              end else begin
                ptr_d = cnt_q - CW'(1); wp_d = '0; state_d = dspq_pkg::ST_INS;
              end
            end
            dspq_pkg::REQ_RM_HEAD, dspq_pkg::REQ_RM_TAIL, dspq_pkg::REQ_RM_AT: begin
              ptr_d = (req_type_i == dspq_pkg::REQ_RM_HEAD) ? '0 :
                      (req_type_i == dspq_pkg::REQ_RM_TAIL) ? cnt_q - CW'(1) :
                      CW'(position_i);
              if (cnt_q != '0 && ptr_d < cnt_q) state_d = dspq_pkg::ST_RM;
            end
            dspq_pkg::REQ_DEDUP: begin
              ok_d = 1'b1;
              if (cnt_q > CW'(1)) begin
                ptr_d = '0; wp_d = CW'(1); state_d = dspq_pkg::ST_DD;
              end
            end
            default: ;
          endcase
        end
      end
      dspq_pkg::ST_INS: begin
        // read ptr; when data returns, shift up or place the new point
        if (!rv_q) begin
          rv_d = 1'b1; rptr_d = ptr_q;
        end else if (!stays) begin
          we = 1'b1; waddr = IW'(rptr_q + CW'(1)); wdata = rdata;
          if (rptr_q == '0) begin
            // the new point is written to the head in the next cycle by the block below
            ptr_d = '0; state_d = dspq_pkg::ST_INS;
            rv_d = 1'b0; wp_d = '1;
          end else begin
            ptr_d = rptr_q - CW'(1); raddr = IW'(ptr_d);
            rv_d = 1'b1; rptr_d = ptr_d;
          end
        end else begin
          we = 1'b1; waddr = IW'(rptr_q + CW'(1));
          cnt_d = cnt_q + CW'(1); ok_d = 1'b1; state_d = dspq_pkg::ST_DONE;
        end
        if (wp_q == '1 && !rv_q) begin
          // the new point goes to the head
          we = 1'b1; waddr = '0; rv_d = 1'b0; wp_d = '0;
          cnt_d = cnt_q + CW'(1); ok_d = 1'b1; state_d = dspq_pkg::ST_DONE;
        end
      end
      dspq_pkg::ST_RM: begin
        // first read returns the removed point, then shift the tail down
        if (!rv_q) begin
          rv_d = 1'b1; rptr_d = ptr_q; ptr_d = ptr_q + CW'(1);
        end else begin
          if (!ok_q) begin
            ok_d = 1'b1; ox_d = rdata.x; oy_d = rdata.y;
          end else begin
            we = 1'b1; waddr = IW'(rptr_q - CW'(1)); wdata = rdata;
          end
          if (rptr_q + CW'(1) >= cnt_q) begin
            cnt_d = cnt_q - CW'(1); state_d = dspq_pkg::ST_DONE;
          end else begin
            raddr = IW'(ptr_q); rv_d = 1'b1; rptr_d = ptr_q; ptr_d = ptr_q + CW'(1);
          end
        end
      end
      dspq_pkg::ST_DD: begin
        if (!rv_q) begin
          rv_d = 1'b1; rptr_d = ptr_q; ptr_d = ptr_q + CW'(1);
        end else begin
          if (rptr_q == '0) begin
            last_d = rdata;
          end else if (rdata.x == last_q.x && rdata.y == last_q.y) begin
            if (dups_q != '1) dups_d = dups_q + 6'd1;
          end else begin
            we = 1'b1; waddr = IW'(wp_q); wdata = rdata;
            wp_d = wp_q + CW'(1); last_d = rdata;
          end
          if (rptr_q + CW'(1) >= cnt_q) begin
            cnt_d = wp_d; state_d = dspq_pkg::ST_DONE;
          end else begin
            raddr = IW'(ptr_q); rv_d = 1'b1; rptr_d = ptr_q; ptr_d = ptr_q + CW'(1);
          end
        end
      end
      dspq_pkg::ST_DONE: begin
        done_d = 1'b1; state_d = dspq_pkg::ST_IDLE;
      end
      default: state_d = dspq_pkg::ST_IDLE;
    endcase
  end

  assign busy            = (state_q != dspq_pkg::ST_IDLE) || done_q;
  assign done_o          = done_q;
  assign ok_o            = ok_q;
  assign out_x_o         = ox_q;
  assign out_y_o         = oy_q;
  assign removed_count_o = dups_q;
  assign entry_count_o   = 7'(cnt_q);

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(dspq_pkg::CAPACITY)) else $error("count over capacity");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy && state_q == dspq_pkg::ST_IDLE |-> done_q) else $error("stray busy");
endmodule

// ----- hdl/dspq_ram.sv -----
// Single-port-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
module dspq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- tb/tb_distance_sorted_point_queue_core.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the distance-sorted point queue core.
// Depends on dspq_pkg and distance_sorted_point_queue_core.
module tb_distance_sorted_point_queue_core;

  typedef struct {
    logic [2:0]        req;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [5:0]        pos;
  } request_t;

  typedef struct {
    logic              ok;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [5:0]        dups;
    logic [6:0]        count;
  } outcome_t;

  logic clk_i, rst_ni, start, busy;
  logic [2:0] req_type_i;
  logic signed [15:0] x_coord_i, y_coord_i;
  logic [5:0] position_i;
  logic done_o, ok_o;
  logic signed [15:0] out_x_o, out_y_o;
  logic [5:0] removed_count_o;
  logic [6:0] entry_count_o;

  distance_sorted_point_queue_core DUT (.*);

  request_t pending_reqs[$];
  outcome_t expected_outcomes[$];
  logic signed [15:0] held_x[$];
  logic signed [15:0] held_y[$];
  int errors = 0;
  bit calm = 0;
  bit took_beat = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [32:0] dist_key(logic signed [15:0] x, logic signed [15:0] y);
    logic signed [32:0] sx, sy;
    sx = x;
    sy = y;
    return sx * sx + sy * sy;
  endfunction

  // true when held point i stays ahead of the new point
  function automatic bit keeps_lead(int i, logic signed [15:0] x, logic signed [15:0] y);
    logic [32:0] ki, kn;
    ki = dist_key(held_x[i], held_y[i]);
    kn = dist_key(x, y);
    if (ki != kn) return ki < kn;
    if (held_x[i] != x) return held_x[i] < x;
    return held_y[i] <= y;
  endfunction

  function automatic outcome_t predict_queue(request_t r);
    outcome_t o;
    int i, n;
    o = '{ok: 0, x: 0, y: 0, dups: 0, count: 0};
    n = held_x.size();
    case (r.req)
      dspq_pkg::REQ_INSERT: if (n < dspq_pkg::CAPACITY) begin
        i = n;
        while (i > 0 && !keeps_lead(i - 1, r.x, r.y)) i--;
        held_x.insert(i, r.x);
        held_y.insert(i, r.y);
        o.ok = 1;
      end
      dspq_pkg::REQ_RM_HEAD, dspq_pkg::REQ_RM_TAIL, dspq_pkg::REQ_RM_AT: begin
        i = (r.req == dspq_pkg::REQ_RM_HEAD) ? 0 :
            (r.req == dspq_pkg::REQ_RM_TAIL) ? n - 1 : int'(r.pos);
        if (n > 0 && i < n) begin
          o.ok = 1;
          o.x = held_x[i];
          o.y = held_y[i];
          held_x.delete(i);
          held_y.delete(i);
        end
      end
      dspq_pkg::REQ_DEDUP: begin
        o.ok = 1;
        i = 1;
        while (i < held_x.size()) begin
          if (held_x[i] == held_x[i-1] && held_y[i] == held_y[i-1]) begin
            held_x.delete(i);
            held_y.delete(i);
            o.dups = (o.dups == 6'd63) ? 6'd63 : o.dups + 6'd1;
          end else i++;
        end
      end
      default: ;
    endcase
    o.count = 7'(held_x.size());
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // note whether the beat on the ports was taken at this edge
  always @(posedge clk_i) begin
    took_beat <= rst_ni && start && !busy;
  end

  // driver: advance on accepted beats, idle at random
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 0;
      req_type_i <= 0;
      x_coord_i <= 0;
      y_coord_i <= 0;
      position_i <= 0;
    end else if (!start || took_beat) begin
      if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 26)) begin
        request_t r;
        r = pending_reqs.pop_front();
        expected_outcomes.push_back(predict_queue(r));
        start <= 1;
        req_type_i <= r.req;
        x_coord_i <= r.x;
        y_coord_i <= r.y;
        position_i <= r.pos;
      end else begin
        start <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        outcome_t e;
        e = expected_outcomes.pop_front();
        if (ok_o !== e.ok) report_mismatch("ok", ok_o, e.ok);
        if (out_x_o !== e.x) report_mismatch("out_x", out_x_o, e.x);
        if (out_y_o !== e.y) report_mismatch("out_y", out_y_o, e.y);
        if (removed_count_o !== e.dups) report_mismatch("removed_count", removed_count_o, e.dups);
        if (entry_count_o !== e.count) report_mismatch("entry_count", entry_count_o, e.count);
      end
    end
  end

  function automatic request_t pick_point(int spread);
    request_t r;
    r.req = dspq_pkg::REQ_INSERT;
    r.pos = 6'($urandom);
    if (spread == 0) begin
      r.x = 16'($urandom_range(4) - 2);
      r.y = 16'($urandom_range(4) - 2);
    end else begin
      r.x = 16'($urandom);
      r.y = 16'($urandom);
    end
    return r;
  endfunction

  task automatic queue_req(logic [2:0] t, logic signed [15:0] x, logic signed [15:0] y, logic [5:0] p);
    pending_reqs.push_back('{req: t, x: x, y: y, pos: p});
  endtask

  initial begin
    int i, k, sel;
    request_t r;
    rst_ni = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1;
    // empty-store cases, extremes and ties
    queue_req(dspq_pkg::REQ_RM_HEAD, 0, 0, 0);
    queue_req(dspq_pkg::REQ_RM_TAIL, 0, 0, 0);
    queue_req(dspq_pkg::REQ_RM_AT, 0, 0, 0);
    queue_req(dspq_pkg::REQ_DEDUP, 0, 0, 0);
    queue_req(3'd5, 16'sh7fff, 16'sh7fff, 6'd63);
    queue_req(dspq_pkg::REQ_INSERT, -16'sd32768, -16'sd32768, 0);
    queue_req(dspq_pkg::REQ_DEDUP, 0, 0, 0);
    queue_req(dspq_pkg::REQ_INSERT, 16'sd32767, 16'sd32767, 6'd63);
    queue_req(dspq_pkg::REQ_INSERT, 3, 4, 0);
    queue_req(dspq_pkg::REQ_INSERT, -3, 4, 0);
    queue_req(dspq_pkg::REQ_INSERT, 3, -4, 0);
    queue_req(dspq_pkg::REQ_INSERT, 3, 4, 0);
    queue_req(dspq_pkg::REQ_INSERT, 4, 3, 0);
    queue_req(dspq_pkg::REQ_INSERT, 3, 4, 0);
    queue_req(dspq_pkg::REQ_DEDUP, 0, 0, 0);
    queue_req(dspq_pkg::REQ_RM_AT, 0, 0, 6'd63);
    queue_req(dspq_pkg::REQ_RM_AT, 0, 0, 6'd2);
    queue_req(3'd7, 0, 0, 0);
    queue_req(dspq_pkg::REQ_RM_TAIL, 0, 0, 0);
    queue_req(dspq_pkg::REQ_RM_HEAD, 0, 0, 0);
    // fill to capacity, overflow, then remove at the last index and dedup
    for (i = 0; i < 66; i++) pending_reqs.push_back(pick_point(i % 2));
    queue_req(dspq_pkg::REQ_RM_AT, 0, 0, 6'd63);
    queue_req(dspq_pkg::REQ_DEDUP, 0, 0, 0);
    for (i = 0; i < 1300; i++) begin
      k = $urandom_range(99);
      if (k < 45) r = pick_point($urandom_range(2) == 0);
      else begin
        r.x = 16'($urandom);
        r.y = 16'($urandom);
        r.pos = (k < 70) ? 6'($urandom_range(7)) : 6'($urandom);
        sel = $urandom_range(99);
        r.req = sel < 25 ? dspq_pkg::REQ_RM_HEAD : sel < 50 ? dspq_pkg::REQ_RM_TAIL :
                sel < 85 ? dspq_pkg::REQ_RM_AT : sel < 96 ? dspq_pkg::REQ_DEDUP :
                3'($urandom_range(7, 5));
      end
      pending_reqs.push_back(r);
    end
    wait (pending_reqs.size() < 700);
    calm = 1;
    wait (pending_reqs.size() < 400);
    calm = 0;
    wait (pending_reqs.size() == 0 && expected_outcomes.size() == 0);
    repeat (80) @(posedge clk_i);
    if (errors == 0) $display("tb_distance_sorted_point_queue_core OK");
    else $display("tb_distance_sorted_point_queue_core NOT OK");
    $finish;
  end

  initial begin
    #10000000;
    $display("tb_distance_sorted_point_queue_core NOT OK");
    $finish;
  end
endmodule
